>>> rtl/sitc_pkg.sv
// Types, codes and arming logic shared by the staged idle timeout controller
`timescale 1ns / 1ps
package sitc_pkg;

    localparam int THR_W  = 16;
    localparam int WARN_W = 8;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_ACTIVITY = 3'd1,
        OP_INH_ADD  = 3'd2,
        OP_INH_REM  = 3'd3,
        OP_REARM    = 3'd4
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIM  = 2'd0,
        CFG_LOCK = 2'd1,
        CFG_OFF  = 2'd2
    } t_cfg_idx;

    localparam logic [1:0] STAGE_DIM  = 2'd0;
    localparam logic [1:0] STAGE_LOCK = 2'd1;
    localparam logic [1:0] STAGE_OFF  = 2'd2;
    localparam logic [1:0] STAGE_DONE = 2'd3;

    typedef struct packed {
        logic [THR_W-1:0] dim_s;
        logic [THR_W-1:0] lock_s;
        logic [THR_W-1:0] off_s;
    } t_thresh;

    typedef struct packed {
        logic       dim_on;
        logic       screen_off;
        logic       lock_request;
        logic       warn_notice;
        logic [1:0] next_stage;
        logic       timer_running;
    } t_result;

    typedef struct packed {
        logic             armed;
        logic             pending;
        logic [THR_W-1:0] count;
    } t_arm;

    function automatic logic [THR_W-1:0] thr_at(input t_thresh thr, input logic [1:0] s);
        logic [THR_W-1:0] v;
        unique case (s)
            STAGE_DIM:  v = thr.dim_s;
            STAGE_LOCK: v = thr.lock_s;
            STAGE_OFF:  v = thr.off_s;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // first enabled stage at or after s, STAGE_DONE if none
    function automatic logic [1:0] find_target(input logic [1:0] s, input t_thresh thr);
        logic [1:0] t;
        t = STAGE_DONE;
        if (s <= STAGE_OFF && thr.off_s != '0) t = STAGE_OFF;
        if (s <= STAGE_LOCK && thr.lock_s != '0) t = STAGE_LOCK;
        if (s == STAGE_DIM && thr.dim_s != '0) t = STAGE_DIM;
        return t;
    endfunction

    function automatic t_arm arm_calc(
        input logic [1:0]        s,
        input logic              given,
        input logic              inhibited,
        input t_thresh           thr,
        input logic [WARN_W-1:0] warn
    );
        t_arm              a;
        logic [1:0]        target;
        logic [THR_W-1:0]  m01;
        logic [THR_W-1:0]  m012;
        logic [THR_W-1:0]  reached_u;
        logic signed [17:0] next_v;
        logic signed [17:0] reached_v;
        logic signed [17:0] warn_v;
        logic signed [17:0] lock_v;
        logic signed [17:0] delay;
        target = find_target(s, thr);
        m01  = (thr.lock_s > thr.dim_s) ? thr.lock_s : thr.dim_s;
        m012 = (thr.off_s > m01) ? thr.off_s : m01;
        unique case (s)
            STAGE_DIM:  reached_u = '0;
            STAGE_LOCK: reached_u = thr.dim_s;
            STAGE_OFF:  reached_u = m01;
            default:    reached_u = m012;
        endcase
        next_v    = $signed({2'b00, thr_at(thr, target)});
        reached_v = $signed({2'b00, reached_u});
        warn_v    = $signed({{(18 - WARN_W){1'b0}}, warn});
        lock_v    = $signed({2'b00, thr.lock_s});
        a.pending = 1'b0;
        if (target == STAGE_LOCK) begin
            if (!given && (next_v - reached_v) > warn_v) begin
                next_v    = next_v - warn_v;
                a.pending = 1'b1;
            end else if (given && (lock_v - warn_v) > reached_v) begin
                reached_v = lock_v - warn_v;
            end
        end
        delay = next_v - reached_v;
        if (delay < 18'sd1) delay = 18'sd1;
        a.count = delay[THR_W-1:0];
        a.armed = !(target == STAGE_DONE || inhibited);
        if (!a.armed) a.pending = 1'b0;
        return a;
    endfunction

endpackage

>>> rtl/sitc_in_if.sv
// Input item channel: op code and session lock flag
`timescale 1ns / 1ps
interface sitc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic       session_locked;

    modport source (output valid, output op, output session_locked, input ready);
    modport sink   (input valid, input op, input session_locked, output ready);
endinterface

>>> rtl/sitc_out_if.sv
// Result item channel: display levels, pulses and countdown status
`timescale 1ns / 1ps
interface sitc_out_if;
    logic       valid;
    logic       ready;
    logic       dim_on;
    logic       screen_off;
    logic       lock_request;
    logic       warn_notice;
    logic [1:0] next_stage;
    logic       timer_running;

    modport source (output valid, output dim_on, output screen_off, output lock_request,
                    output warn_notice, output next_stage, output timer_running,
                    input ready);
    modport sink   (input valid, input dim_on, input screen_off, input lock_request,
                    input warn_notice, input next_stage, input timer_running,
                    output ready);
endinterface

>>> rtl/staged_idle_timeout_controller.sv
// Top level of the staged idle timeout controller
//
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  i_in     | in        | op, session_locked
//  o_out    | out       | dim_on, screen_off, lock_request, warn_notice,
//           |           | next_stage, timer_running
//  i_cfg_*  | in        | write enable, register index, 16-bit threshold
//
// One item per cycle while the result register has space; its result is presented in the cycle after acceptance.
// The state update is a single pass through the arming logic into the
// state registers, with the result captured in one output register.
// i_in.ready is high while the result register is empty or being taken.
// Reset is synchronous; thresholds come up at 300, 600 and 900 seconds.
`timescale 1ns / 1ps
module staged_idle_timeout_controller #(
    parameter int LOCK_WARN_SECONDS = 10,
    parameter int INHIBIT_BITS      = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sitc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sitc_pkg::THR_W-1:0]     i_cfg_data,
    sitc_in_if.sink                        i_in,
    sitc_out_if.source                     o_out
);

    sitc_pkg::t_thresh w_thr;
    sitc_pkg::t_result w_res;
    logic              w_space;
    logic              w_accept;

    assign i_in.ready = w_space;
    assign w_accept   = i_in.valid && w_space;

    sitc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thr      (w_thr)
    );

    sitc_core #(
        .LOCK_WARN_SECONDS (LOCK_WARN_SECONDS),
        .INHIBIT_BITS      (INHIBIT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (i_in.op),
        .i_locked (i_in.session_locked),
        .i_thr    (w_thr),
        .o_res    (w_res)
    );

    sitc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept),
        .i_res   (w_res),
        .o_space (w_space),
        .o_out   (o_out)
    );

endmodule

>>> rtl/sitc_cfg.sv
// Threshold registers written through the configuration port
`timescale 1ns / 1ps
module sitc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sitc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sitc_pkg::THR_W-1:0]     i_cfg_data,
    output sitc_pkg::t_thresh              o_thr
);

    sitc_pkg::t_thresh r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.dim_s  <= 16'd300;
            r_thr.lock_s <= 16'd600;
            r_thr.off_s  <= 16'd900;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sitc_pkg::CFG_DIM:  r_thr.dim_s  <= i_cfg_data;
                sitc_pkg::CFG_LOCK: r_thr.lock_s <= i_cfg_data;
                sitc_pkg::CFG_OFF:  r_thr.off_s  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_thr = r_thr;

endmodule

>>> rtl/sitc_core.sv
// Stage state, inhibit count and countdown, updated once per accepted item
`timescale 1ns / 1ps
module sitc_core #(
    parameter int LOCK_WARN_SECONDS = 10,
    parameter int INHIBIT_BITS      = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_op,
    input  logic              i_locked,
    input  sitc_pkg::t_thresh i_thr,
    output sitc_pkg::t_result o_res
);

    localparam logic [sitc_pkg::WARN_W-1:0] WARN = sitc_pkg::WARN_W'(LOCK_WARN_SECONDS);

    logic [1:0]                 r_stage, n_stage;
    logic [INHIBIT_BITS-1:0]    r_inh, n_inh;
    logic                       r_pending, n_pending;
    logic                       r_given, n_given;
    logic [sitc_pkg::THR_W-1:0] r_count, n_count;
    logic                       r_armed, n_armed;
    logic                       r_dim, n_dim;
    logic                       r_off, n_off;

    logic            w_lock;
    logic            w_warn;
    logic            w_do_arm;
    logic [1:0]      w_arm_stage;
    logic            w_arm_given;
    logic [1:0]      w_target;
    sitc_pkg::t_arm  w_arm;

    always_comb begin
        n_stage     = r_stage;
        n_inh       = r_inh;
        n_pending   = r_pending;
        n_given     = r_given;
        n_count     = r_count;
        n_armed     = r_armed;
        n_dim       = r_dim;
        n_off       = r_off;
        w_lock      = 1'b0;
        w_warn      = 1'b0;
        w_do_arm    = 1'b0;
        w_arm_stage = r_stage;
        w_arm_given = r_given;
        w_target    = sitc_pkg::find_target(r_stage, i_thr);
        unique case (i_op)
            sitc_pkg::OP_TICK: begin
                if (r_armed) begin
                    if (r_count <= 16'd1) begin
                        n_count = '0;
                        n_armed = 1'b0;
                        if (r_pending) begin
                            n_pending   = 1'b0;
                            n_given     = 1'b1;
                            w_warn      = !i_locked;
                            w_arm_given = 1'b1;
                            w_do_arm    = 1'b1;
                        end else if (w_target != sitc_pkg::STAGE_DONE) begin
                            unique case (w_target)
                                sitc_pkg::STAGE_DIM:  n_dim = 1'b1;
                                sitc_pkg::STAGE_LOCK: w_lock = !i_locked;
                                default:              n_off = 1'b1;
                            endcase
                            n_stage     = w_target + 2'd1;
                            w_arm_stage = w_target + 2'd1;
                            w_do_arm    = 1'b1;
                        end
                    end else begin
                        n_count = r_count - 16'd1;
                    end
                end
            end
            sitc_pkg::OP_ACTIVITY: begin
                if (r_stage != sitc_pkg::STAGE_DIM || r_given) begin
                    if (r_stage == sitc_pkg::STAGE_DONE) n_off = 1'b0;
                    n_dim   = 1'b0;
                    n_stage = sitc_pkg::STAGE_DIM;
                    n_given = 1'b0;
                end
                w_arm_stage = sitc_pkg::STAGE_DIM;
                w_arm_given = 1'b0;
                w_do_arm    = 1'b1;
            end
            sitc_pkg::OP_INH_ADD: begin
                if (r_inh != '1) n_inh = r_inh + INHIBIT_BITS'(1);
                w_do_arm = 1'b1;
            end
            sitc_pkg::OP_INH_REM: begin
                if (r_inh != '0) n_inh = r_inh - INHIBIT_BITS'(1);
                w_do_arm = 1'b1;
            end
            sitc_pkg::OP_REARM: begin
                n_given     = 1'b0;
                w_arm_given = 1'b0;
                w_do_arm    = 1'b1;
            end
            default: ;
        endcase
        w_arm = sitc_pkg::arm_calc(w_arm_stage, w_arm_given, n_inh != '0, i_thr, WARN);
        if (w_do_arm) begin
            n_pending = w_arm.pending;
            n_armed   = w_arm.armed;
            if (w_arm.armed) n_count = w_arm.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage   <= sitc_pkg::STAGE_DIM;
            r_inh     <= '0;
            r_pending <= 1'b0;
            r_given   <= 1'b0;
            r_count   <= '0;
            r_armed   <= 1'b0;
            r_dim     <= 1'b0;
            r_off     <= 1'b0;
        end else if (i_accept) begin
            r_stage   <= n_stage;
            r_inh     <= n_inh;
            r_pending <= n_pending;
            r_given   <= n_given;
            r_count   <= n_count;
            r_armed   <= n_armed;
            r_dim     <= n_dim;
            r_off     <= n_off;
        end
    end

    always_comb begin
        o_res.dim_on        = n_dim;
        o_res.screen_off    = n_off;
        o_res.lock_request  = w_lock;
        o_res.warn_notice   = w_warn;
        o_res.next_stage    = n_stage;
        o_res.timer_running = n_armed;
    end

    a_lock_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_lock) |=> (r_stage == sitc_pkg::STAGE_OFF))
        else $error("lock pulse without advancing to the off stage");

    a_warn_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && w_warn) |=> r_given)
        else $error("warning pulse without marking the warning given");

    a_inhibit_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_op == sitc_pkg::OP_INH_ADD) |=> (!r_armed && r_inh != '0))
        else $error("countdown still armed after an inhibitor was added");

    a_pending_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_armed)
        else $error("warning pending while the countdown is disarmed");

endmodule

>>> rtl/sitc_out.sv
// Result register between the state update and the result channel
`timescale 1ns / 1ps
module sitc_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sitc_pkg::t_result i_res,
    output logic              o_space,
    sitc_out_if.source        o_out
);

    logic              r_valid;
    sitc_pkg::t_result r_res;

    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.dim_on        = r_res.dim_on;
    assign o_out.screen_off    = r_res.screen_off;
    assign o_out.lock_request  = r_res.lock_request;
    assign o_out.warn_notice   = r_res.warn_notice;
    assign o_out.next_stage    = r_res.next_stage;
    assign o_out.timer_running = r_res.timer_running;

endmodule

>>> tb/staged_idle_timeout_controller_tb.sv
// Self-checking testbench for the staged idle timeout controller
`timescale 1ns / 1ps
module staged_idle_timeout_controller_tb;
    import sitc_pkg::*;

    localparam int WARN_LEAD       = 10;
    localparam int INH_BITS        = 8;
    localparam int INH_CEIL        = (1 << INH_BITS) - 1;
    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SPELL_PHASES    = 10;
    localparam int SPELL_ITEMS     = 85;
    localparam int FLOOD_DEPTH     = INH_CEIL + 3;
    localparam int MAX_REPORTS     = 20;

    localparam logic [2:0] OP_RSV_LO  = 3'd5;
    localparam logic [2:0] OP_RSV_MID = 3'd6;
    localparam logic [2:0] OP_RSV_HI  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic       locked;
    } idle_event_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_MASK, RX_MOSTLY} rx_style_e;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_DIM;
    logic [THR_W-1:0]  i_cfg_data = '0;

    sitc_in_if  evt_if ();
    sitc_out_if disp_if ();

    staged_idle_timeout_controller #(
        .LOCK_WARN_SECONDS (WARN_LEAD),
        .INHIBIT_BITS      (INH_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (evt_if),
        .o_out      (disp_if)
    );

    always #1 i_clk = ~i_clk;

    // predictor copy of thresholds and idle state
    logic [THR_W-1:0] thr_dim  = 16'd300;
    logic [THR_W-1:0] thr_lock = 16'd600;
    logic [THR_W-1:0] thr_off  = 16'd900;

    logic [1:0]       spell_stage = STAGE_DIM;
    int               inh_cnt     = 0;
    logic             warn_pend   = 1'b0;
    logic             warn_given  = 1'b0;
    logic [THR_W-1:0] secs_left   = '0;
    logic             timer_armed = 1'b0;
    logic             dim_lvl     = 1'b0;
    logic             off_lvl     = 1'b0;

    idle_event_t pending_events[$];
    t_result     expected_display[$];

    int n_items    = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int n_locks    = 0;
    int n_warnings = 0;

    function automatic int stage_thr(input int s);
        case (s)
            STAGE_DIM:  return int'(thr_dim);
            STAGE_LOCK: return int'(thr_lock);
            STAGE_OFF:  return int'(thr_off);
            default:    return 0;
        endcase
    endfunction

    function automatic void rearm_timer();
        int s;
        int tgt;
        int nxt;
        int reached;
        int dly;
        tgt = STAGE_DONE;
        reached = 0;
        warn_pend = 1'b0;
        for (s = spell_stage; s < STAGE_DONE; s++) begin
            if (stage_thr(s) > 0) begin
                tgt = s;
                break;
            end
        end
        if (tgt >= STAGE_DONE || inh_cnt > 0) begin
            timer_armed = 1'b0;
            return;
        end
        nxt = stage_thr(tgt);
        for (s = 0; s < spell_stage && s < STAGE_DONE; s++) begin
            if (stage_thr(s) > reached) reached = stage_thr(s);
        end
        if (tgt == STAGE_LOCK) begin
            if (!warn_given && nxt - reached > WARN_LEAD) begin
                nxt = nxt - WARN_LEAD;
                warn_pend = 1'b1;
            end else if (warn_given && stage_thr(STAGE_LOCK) - WARN_LEAD > reached) begin
                reached = stage_thr(STAGE_LOCK) - WARN_LEAD;
            end
        end
        dly = nxt - reached;
        if (dly < 1) dly = 1;
        secs_left = dly[THR_W-1:0];
        timer_armed = 1'b1;
    endfunction

    // returns {lock pulse, warning pulse}
    function automatic logic [1:0] run_expiry(input logic locked);
        int s;
        logic [1:0] pulses;
        pulses = 2'b00;
        if (warn_pend) begin
            warn_pend = 1'b0;
            warn_given = 1'b1;
            if (!locked) pulses[0] = 1'b1;
            rearm_timer();
            return pulses;
        end
        s = spell_stage;
        while (s < STAGE_DONE && stage_thr(s) <= 0) s++;
        if (s >= STAGE_DONE) return pulses;
        if (s == STAGE_DIM) begin
            dim_lvl = 1'b1;
        end else if (s == STAGE_LOCK) begin
            if (!locked) pulses[1] = 1'b1;
        end else begin
            off_lvl = 1'b1;
        end
        spell_stage = 2'(s + 1);
        rearm_timer();
        return pulses;
    endfunction

    function automatic t_result next_display_state(input logic [2:0] op, input logic locked);
        t_result r;
        logic [1:0] pulses;
        pulses = 2'b00;
        case (op)
            OP_TICK: begin
                if (timer_armed) begin
                    if (secs_left <= 1) begin
                        secs_left = '0;
                        timer_armed = 1'b0;
                        pulses = run_expiry(locked);
                    end else begin
                        secs_left = secs_left - 1'b1;
                    end
                end
            end
            OP_ACTIVITY: begin
                if (spell_stage != STAGE_DIM || warn_given) begin
                    if (spell_stage > STAGE_OFF) off_lvl = 1'b0;
                    dim_lvl = 1'b0;
                    spell_stage = STAGE_DIM;
                    warn_given = 1'b0;
                end
                rearm_timer();
            end
            OP_INH_ADD: begin
                if (inh_cnt < INH_CEIL) inh_cnt++;
                rearm_timer();
            end
            OP_INH_REM: begin
                if (inh_cnt > 0) inh_cnt--;
                rearm_timer();
            end
            OP_REARM: begin
                warn_given = 1'b0;
                rearm_timer();
            end
            default: ;
        endcase
        r.dim_on        = dim_lvl;
        r.screen_off    = off_lvl;
        r.lock_request  = pulses[1];
        r.warn_notice   = pulses[0];
        r.next_stage    = spell_stage;
        r.timer_running = timer_armed;
        return r;
    endfunction

    task automatic push_event(input logic [2:0] op, input logic locked);
        idle_event_t e;
        e.op = op;
        e.locked = locked;
        pending_events.push_back(e);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_events.size() != 0 || evt_if.valid || expected_display.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic settle_and_set(input logic [THR_W-1:0] d, input logic [THR_W-1:0] l,
                                  input logic [THR_W-1:0] o);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DIM;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LOCK;
        i_cfg_data <= l;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFF;
        i_cfg_data <= o;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_dim  = d;
        thr_lock = l;
        thr_off  = o;
        n_settings++;
        @(negedge i_clk);
    endtask

    // rearm, then mostly ticks with activity, inhibit changes and noise mixed in
    task automatic queue_idle_spells(input int count);
        int k;
        int r;
        logic lk;
        lk = 1'($urandom);
        push_event(OP_REARM, lk);
        for (k = 1; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) lk = ~lk;
            r = $urandom_range(0, 99);
            if (r < 70)      push_event(OP_TICK, lk);
            else if (r < 78) push_event(OP_ACTIVITY, lk);
            else if (r < 84) push_event(OP_INH_ADD, lk);
            else if (r < 91) push_event(OP_INH_REM, lk);
            else if (r < 96) push_event(OP_REARM, lk);
            else             push_event(3'($urandom_range(OP_RSV_LO, OP_RSV_HI)), lk);
        end
    endtask

    function automatic logic [THR_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'($urandom_range(2, 15));
            default: return '1;
        endcase
    endfunction

    // sender: bursts with random gaps
    idle_event_t drv_item;
    int          burst_left = 1;
    int          gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.valid <= 1'b0;
        end else if (!evt_if.valid || evt_if.ready) begin
            if (gap_left != 0) begin
                evt_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_events.size() != 0) begin
                drv_item = pending_events.pop_front();
                evt_if.valid          <= 1'b1;
                evt_if.op             <= drv_item.op;
                evt_if.session_locked <= drv_item.locked;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // predict at each accepted item
    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            expected_display.push_back(next_display_state(evt_if.op, evt_if.session_locked));
            n_items++;
        end
    end

    // receiver: changing stall styles plus one long hold-off
    logic      hold_off_req  = 1'b0;
    logic      hold_off_done = 1'b0;
    int        hold_left     = 0;
    rx_style_e rx_mode       = RX_OPEN;
    int        rx_left       = 0;
    logic [15:0] rx_mask     = 16'hFFFF;
    logic [3:0]  rx_phase    = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            disp_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            disp_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_off_req && !hold_off_done) begin
            disp_if.ready <= 1'b0;
            hold_left     <= HOLD_OFF_CYCLES - 1;
            hold_off_done <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_style_e'($urandom_range(0, 3));
                rx_mask <= 16'($urandom);
                rx_left <= $urandom_range(32, 256);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= rx_phase + 1'b1;
            case (rx_mode)
                RX_OPEN:   disp_if.ready <= 1'b1;
                RX_COIN:   disp_if.ready <= 1'($urandom);
                RX_MASK:   disp_if.ready <= rx_mask[rx_phase];
                default:   disp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // compare each result against the oldest prediction
    t_result mon_exp;
    t_result mon_got;

    always @(posedge i_clk) begin
        if (i_rst_n && disp_if.valid && disp_if.ready) begin
            n_results++;
            mon_got.dim_on        = disp_if.dim_on;
            mon_got.screen_off    = disp_if.screen_off;
            mon_got.lock_request  = disp_if.lock_request;
            mon_got.warn_notice   = disp_if.warn_notice;
            mon_got.next_stage    = disp_if.next_stage;
            mon_got.timer_running = disp_if.timer_running;
            if (mon_got.lock_request === 1'b1) n_locks++;
            if (mon_got.warn_notice === 1'b1) n_warnings++;
            if (expected_display.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, got %p", $time, mon_got);
            end else begin
                mon_exp = expected_display.pop_front();
                if (mon_got.dim_on !== mon_exp.dim_on ||
                    mon_got.screen_off !== mon_exp.screen_off ||
                    mon_got.lock_request !== mon_exp.lock_request ||
                    mon_got.warn_notice !== mon_exp.warn_notice ||
                    mon_got.next_stage !== mon_exp.next_stage ||
                    mon_got.timer_running !== mon_exp.timer_running) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("%0t: result mismatch, expected %p, got %p",
                                 $time, mon_exp, mon_got);
                end
            end
        end
    end

    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((evt_if.valid && evt_if.ready) || (disp_if.valid && disp_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no progress for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_CYCLES, expected_display.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int p;
        int k;
        logic [THR_W-1:0] d;
        logic [THR_W-1:0] l;
        logic [THR_W-1:0] o;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset thresholds: disarmed tick, reserved ops, inhibit edges
        push_event(OP_TICK, 1'b0);
        push_event(OP_RSV_LO, 1'b1);
        push_event(OP_RSV_MID, 1'b0);
        push_event(OP_RSV_HI, 1'b1);
        push_event(OP_INH_REM, 1'b0);
        push_event(OP_INH_ADD, 1'b1);
        push_event(OP_TICK, 1'b0);
        push_event(OP_INH_REM, 1'b1);
        push_event(OP_TICK, 1'b1);
        push_event(OP_ACTIVITY, 1'b0);
        push_event(OP_REARM, 1'b1);

        // walk all three stages one second apart
        settle_and_set(16'd1, 16'd2, 16'd3);
        push_event(OP_REARM, 1'b0);
        push_event(OP_TICK, 1'b0);
        push_event(OP_TICK, 1'b0);
        push_event(OP_TICK, 1'b1);
        push_event(OP_TICK, 1'b0);
        push_event(OP_ACTIVITY, 1'b1);

        // expire with every stage disabled
        settle_and_set(16'd0, 16'd0, 16'd0);
        push_event(OP_TICK, 1'b0);
        push_event(OP_REARM, 1'b0);

        settle_and_set(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_event(OP_REARM, 1'b1);
        push_event(OP_TICK, 1'b0);
        push_event(OP_ACTIVITY, 1'b0);

        for (p = 0; p < SPELL_PHASES; p++) begin
            case (p % 4)
                0: begin
                    d = 16'($urandom_range(1, 6));
                    l = d + 16'($urandom_range(1, 20));
                    o = l + 16'($urandom_range(1, 6));
                end
                1: begin
                    d = 16'($urandom_range(0, 20));
                    l = 16'($urandom_range(0, 20));
                    o = 16'($urandom_range(0, 20));
                end
                2: begin
                    d = 16'($urandom_range(1, 4));
                    l = d + 16'($urandom_range(11, 16));
                    o = l + 16'($urandom_range(1, 3));
                end
                default: begin
                    d = pick_extreme();
                    l = pick_extreme();
                    o = pick_extreme();
                end
            endcase
            settle_and_set(d, l, o);
            queue_idle_spells(SPELL_ITEMS);

            if (p == SPELL_PHASES / 2) begin
                // saturate the inhibit count while the receiver holds off
                settle_and_set(16'd2, 16'd14, 16'd16);
                hold_off_req = 1'b1;
                push_event(OP_REARM, 1'b0);
                for (k = 0; k < FLOOD_DEPTH; k++) push_event(OP_INH_ADD, 1'($urandom));
                push_event(OP_TICK, 1'b0);
                for (k = 0; k < FLOOD_DEPTH; k++) push_event(OP_INH_REM, 1'($urandom));
                for (k = 0; k < 20; k++) push_event(OP_TICK, 1'b0);
            end
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("Ran %0d items through %0d threshold settings, inhibit saturation included,",
                 n_items, n_settings);
        $display("with a %0d-cycle output hold-off; saw %0d lock requests and %0d warnings.",
                 HOLD_OFF_CYCLES, n_locks, n_warnings);
        if (n_errors == 0 && expected_display.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding",
                     n_errors, expected_display.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
